[hdl/mexp_pkg.sv]
package mexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

  typedef logic [OPERAND_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RED,
    S_RED_END,
    S_LOOP,
    S_MUL,
    S_MUL_END,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RES_ERROR,
    RES_ONE,
    RES_ACC
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     start_red;
    logic     fin_red;
    logic     start_mul;
    logic     fin_mul;
    logic     step;
    logic     out_load;
    res_sel_t res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic expo_zero;
    logic cnt_last;
  } ctrl_sts_t;

  // (x + y) mod m for x, y < m
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    word_t room;
    room = m - y;
    if (x >= room) begin
      return x - room;
    end
    return x + y;
  endfunction

endpackage

[hdl/mexp_ifs.sv]
interface mexp_in_if import mexp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t base_value;
  word_t exponent_value;
  word_t modulus_value;

  modport source (output valid, output base_value, output exponent_value,
                  output modulus_value, input ready);
  modport sink (input valid, input base_value, input exponent_value,
                input modulus_value, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t power_result;
  logic  modulus_error;

  modport source (output valid, output power_result, output modulus_error,
                  input ready);
  modport sink (input valid, input power_result, input modulus_error,
                output ready);
endinterface

[hdl/mexp_datapath.sv]
module mexp_datapath import mexp_pkg::*; (
  input  logic      clk,
  input  ctrl_cmd_t cmd,
  input  word_t     base_value,
  input  word_t     exponent_value,
  input  word_t     modulus_value,
  output ctrl_sts_t sts,
  output word_t     power_result,
  output logic      modulus_error
);

  word_t base_r;
  word_t expo_r;
  word_t mod_r;
  word_t acc_r;
  // two interleaved modular multipliers: A forms acc*base, B forms base*base
  word_t mc_a;
  word_t mc_b;
  word_t sh_a;
  word_t sh_b;
  word_t pa;
  word_t pb;
  logic [CNT_W-1:0] cnt;
  word_t one_mod;
  word_t pa_dbl;
  word_t pb_dbl;
  word_t pa_next;
  word_t pb_next;
  word_t res_value;
  logic  res_error;

  function automatic word_t power_result_sel(res_sel_t sel);
    case (sel)
      RES_ERROR: return '0;
      RES_ONE:   return word_t'(1);
      RES_ACC:   return acc_r;
      default:   return '0;
    endcase
  endfunction

  assign one_mod = (mod_r == word_t'(1)) ? '0 : word_t'(1);

  always_comb begin
    pa_dbl  = add_mod(pa, pa, mod_r);
    pb_dbl  = add_mod(pb, pb, mod_r);
    pa_next = add_mod(pa_dbl, sh_a[OPERAND_WIDTH-1] ? mc_a : '0, mod_r);
    pb_next = add_mod(pb_dbl, sh_b[OPERAND_WIDTH-1] ? mc_b : '0, mod_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= base_value;
      expo_r <= exponent_value;
      mod_r  <= modulus_value;
    end
    // base mod m computed as 1 * base on unit B
    if (cmd.start_red) begin
      pb   <= '0;
      mc_b <= one_mod;
      sh_b <= base_r;
      cnt  <= '0;
    end
    if (cmd.fin_red) begin
      base_r <= pb;
      acc_r  <= one_mod;
    end
    if (cmd.start_mul) begin
      pa   <= '0;
      pb   <= '0;
      mc_a <= acc_r;
      sh_a <= base_r;
      mc_b <= base_r;
      sh_b <= base_r;
      cnt  <= '0;
    end
    if (cmd.step) begin
      pa   <= pa_next;
      pb   <= pb_next;
      sh_a <= {sh_a[OPERAND_WIDTH-2:0], 1'b0};
      sh_b <= {sh_b[OPERAND_WIDTH-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
    end
    if (cmd.fin_mul) begin
      if (expo_r[0]) begin
        acc_r <= pa;
      end
      base_r <= pb;
      expo_r <= {1'b0, expo_r[OPERAND_WIDTH-1:1]};
    end
    if (cmd.out_load) begin
      res_value <= power_result_sel(cmd.res_sel);
      res_error <= (cmd.res_sel == RES_ERROR);
    end
  end

  assign sts.mod_zero  = (mod_r == '0);
  assign sts.expo_zero = (expo_r == '0);
  assign sts.cnt_last  = (cnt == CNT_LAST);

  assign power_result  = res_value;
  assign modulus_error = res_error;

endmodule

[hdl/mexp_ctrl.sv]
module mexp_ctrl import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t   state;
  state_t   state_next;
  logic     out_valid_r;
  logic     out_valid_next;
  res_sel_t res_sel_r;
  res_sel_t res_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
      res_sel_r   <= RES_ACC;
    end else begin
      state       <= state_next;
      out_valid_r <= out_valid_next;
      res_sel_r   <= res_sel_next;
    end
  end

  always_comb begin
    state_next     = state;
    res_sel_next   = res_sel_r;
    cmd            = '0;
    cmd.res_sel    = res_sel_r;
    in_ready       = (state == S_IDLE);
    out_valid_next = out_valid_r && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          res_sel_next = RES_ACC;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        // result kind is fixed here and held until the output load
        if (sts.mod_zero) begin
          res_sel_next = RES_ERROR;
          state_next   = S_OUT;
        end else if (sts.expo_zero) begin
          res_sel_next = RES_ONE;
          state_next   = S_OUT;
        end else begin
          cmd.start_red = 1'b1;
          state_next    = S_RED;
        end
      end
      S_RED: begin
        cmd.step = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_RED_END;
        end
      end
      S_RED_END: begin
        cmd.fin_red = 1'b1;
        state_next  = S_LOOP;
      end
      S_LOOP: begin
        if (sts.expo_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.start_mul = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.step = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_MUL_END;
        end
      end
      S_MUL_END: begin
        cmd.fin_mul = 1'b1;
        state_next  = S_LOOP;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/modular_exponentiation_unit.sv]
// Flow: a zero modulus or zero exponent goes from the check straight to the response;
//   otherwise base is reduced mod m, then one pass runs per exponent bit up to the top set bit.
// Handshake: one item at a time; the next item can be taken in the cycle after the result
//   is loaded. Each exponent bit costs one pass of two bit-serial modular multipliers
//   (acc*base, base*base).
// Reset: synchronous, active high; clears the controller and the output valid.
module modular_exponentiation_unit import mexp_pkg::*; (
  input logic clk,
  input logic rst,
  mexp_in_if.sink    request,
  mexp_out_if.source response
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .base_value     (request.base_value),
    .exponent_value (request.exponent_value),
    .modulus_value  (request.modulus_value),
    .sts            (sts),
    .power_result   (response.power_result),
    .modulus_error  (response.modulus_error)
  );

endmodule
